[rtl/core/mmul_pkg.sv]
// package with sizes, mode codes and a helper for the montgomery multiplier
package mmul_pkg;

    localparam int R_BITS = 1038;
    localparam int WORDS = 17;
    localparam int W = 64;
    localparam int IDX_W = 5;
    localparam int AW1 = $clog2(WORDS);
    localparam int AW2 = $clog2(2 * WORDS + 1);
    localparam int WO = R_BITS / W;
    localparam int BO = R_BITS % W;

    localparam logic [2:0] MODE_LD_N = 3'd0;
    localparam logic [2:0] MODE_LD_NP = 3'd1;
    localparam logic [2:0] MODE_LD_A = 3'd2;
    localparam logic [2:0] MODE_LD_B = 3'd3;
    localparam logic [2:0] MODE_MUL = 3'd4;
    localparam logic [2:0] MODE_SQR = 3'd5;

    // mask of word i to the bits below R
    function automatic logic [W-1:0] word_mask(input logic [AW1-1:0] i);
        logic [W-1:0] m;
        int base;
        base = int'(i) * W;
        if (base >= R_BITS) begin
            m = '0;
        end else if (base + W > R_BITS) begin
            m = (W'(1) << (R_BITS - base)) - W'(1);
        end else begin
            m = '1;
        end
        return m;
    endfunction

endpackage

[rtl/core/montgomery_mul_1038.sv]
// Montgomery multiplier, R = 2^1038, 17 words of 64 bits, word-serial schoolbook passes.
// Each load writes one word of n, n', a or b. A multiply or square runs three passes of one 64x64 multiply
// per step through a shared multiplier (t = a*b, q = t*n' mod R, t + q*n), each multiply
// step running through operand read, partial products and accumulate/write, followed by
// a carry fixup after each row of the last pass and a shifted readout of each result word.
// The accumulator s is cleared before the first pass and q before the second. No item is
// accepted while a product runs.
module montgomery_mul_1038 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_mode,
    input  logic [4:0]  i_word_index,
    input  logic [63:0] i_word_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_result_word,
    output logic [4:0]  o_result_index,
    output logic        o_last
);
    localparam int W = mmul_pkg::W;
    localparam int N = mmul_pkg::WORDS;
    localparam int A1 = mmul_pkg::AW1;
    localparam int A2 = mmul_pkg::AW2;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CLR = 4'd1;
    localparam logic [3:0] S_RD = 4'd2;
    localparam logic [3:0] S_MUL = 4'd3;
    localparam logic [3:0] S_ACC = 4'd4;
    localparam logic [3:0] S_CARRY = 4'd5;
    localparam logic [3:0] S_CARRYW = 4'd6;
    localparam logic [3:0] S_OUT0 = 4'd7;
    localparam logic [3:0] S_OUT1 = 4'd8;
    localparam logic [3:0] S_OUT2 = 4'd9;
    localparam logic [3:0] S_SEND = 4'd10;

    localparam logic [1:0] P_T = 2'd0;
    localparam logic [1:0] P_Q = 2'd1;
    localparam logic [1:0] P_S = 2'd2;

    // operand memories: n, n', a, b, q, the product t (2N words) and the accumulator s (2N+1 words)
    logic [W-1:0] m_n [N];
    logic [W-1:0] m_np [N];
    logic [W-1:0] m_a [N];
    logic [W-1:0] m_b [N];
    logic [W-1:0] m_q [N];
    logic [W-1:0] m_t [2*N];
    logic [W-1:0] m_s [2*N+1];

    logic [3:0] r_st, n_st;
    logic [1:0] r_pass, n_pass;
    logic r_sqr, n_sqr;
    logic [A1-1:0] r_i, n_i;
    logic [A1-1:0] r_j, n_j;
    logic [A2-1:0] r_k, n_k;
    logic [W-1:0] r_carry, n_carry;
    logic [W-1:0] r_x, r_y, r_acc, r_lo, r_hi;
    logic [W-1:0] r_out;
    logic [4:0] r_oidx;
    logic r_ov;
    logic [W-1:0] mac_lo, mac_hi;

    logic in_acc;
    logic [A1-1:0] cur_j;
    logic [A2-1:0] ij;
    logic [A2-1:0] top_j;

    assign in_acc = i_valid && !o_stall;
    assign o_stall = (r_st != S_IDLE) || r_ov;
    assign ij = A2'(r_i) + A2'(r_j);

    // last j index of the current row
    always_comb begin
        if (r_pass == P_Q) begin
            top_j = A2'(N - 1) - A2'(r_i);
        end else begin
            top_j = A2'(N - 1);
        end
    end
    assign cur_j = r_j;

    // load writes
    always_ff @(posedge i_clk) begin
        if (in_acc && int'(i_word_index) < N) begin
            case (i_mode)
                mmul_pkg::MODE_LD_N: m_n[i_word_index[A1-1:0]] <= i_word_value;
                mmul_pkg::MODE_LD_NP: m_np[i_word_index[A1-1:0]] <= i_word_value;
                mmul_pkg::MODE_LD_A: m_a[i_word_index[A1-1:0]] <= i_word_value;
                mmul_pkg::MODE_LD_B: m_b[i_word_index[A1-1:0]] <= i_word_value;
                default: ;
            endcase
        end
    end

    // operand read, registered
    always_ff @(posedge i_clk) begin
        if (r_st == S_RD) begin
            case (r_pass)
                P_T: begin
                    r_x <= m_a[r_i] & mmul_pkg::word_mask(r_i);
                    r_y <= (r_sqr ? m_a[cur_j] : m_b[cur_j]) & mmul_pkg::word_mask(cur_j);
                end
                P_Q: begin
                    r_x <= m_t[A2'(r_i)] & mmul_pkg::word_mask(r_i);
                    r_y <= m_np[cur_j] & mmul_pkg::word_mask(cur_j);
                end
                default: begin
                    r_x <= m_q[r_i] & mmul_pkg::word_mask(r_i);
                    r_y <= m_n[cur_j] & mmul_pkg::word_mask(cur_j);
                end
            endcase
            if (r_pass == P_Q) begin
                r_acc <= m_q[ij[A1-1:0]];
            end else begin
                r_acc <= m_s[ij];
            end
        end
    end

    mmul_mac u_mac (
        .i_clk  (i_clk),
        .i_x    (r_x),
        .i_y    (r_y),
        .i_add  (r_acc),
        .i_carry(r_carry),
        .o_lo   (mac_lo),
        .o_hi   (mac_hi)
    );

    // accumulator, t and q writes
    always_ff @(posedge i_clk) begin
        case (r_st)
            S_CLR: begin
                if (r_pass == P_T) begin
                    m_s[r_k] <= '0;
                end else begin
                    m_q[r_k[A1-1:0]] <= '0;
                end
            end
            S_ACC: begin
                if (r_pass == P_Q) begin
                    m_q[ij[A1-1:0]] <= mac_lo;
                end else begin
                    m_s[ij] <= mac_lo;
                end
                if (r_pass == P_T) begin
                    m_t[ij] <= mac_lo;
                    if (r_j == top_j[A1-1:0]) begin
                        m_s[ij + A2'(1)] <= mac_hi;
                        m_t[ij + A2'(1)] <= mac_hi;
                    end
                end
            end
            S_CARRYW: begin
                m_s[r_k] <= r_lo + r_carry;
            end
            default: ;
        endcase
    end

    // registered reads for carry fixup and readout
    always_ff @(posedge i_clk) begin
        if (r_st == S_CARRY) begin
            r_lo <= m_s[r_k];
        end
        if (r_st == S_OUT0) begin
            r_lo <= m_s[r_k];
        end
        if (r_st == S_OUT1) begin
            r_hi <= (int'(r_k) + 1 < 2 * N + 1) ? m_s[r_k + A2'(1)] : '0;
        end
    end

    always_comb begin
        n_st = r_st;
        n_pass = r_pass;
        n_sqr = r_sqr;
        n_i = r_i;
        n_j = r_j;
        n_k = r_k;
        n_carry = r_carry;
        case (r_st)
            S_IDLE: begin
                if (in_acc && (i_mode inside {mmul_pkg::MODE_MUL, mmul_pkg::MODE_SQR})) begin
                    n_sqr = (i_mode == mmul_pkg::MODE_SQR);
                    n_pass = P_T;
                    n_k = '0;
                    n_st = S_CLR;
                end
            end
            S_CLR: begin
                if ((r_pass == P_T && int'(r_k) == 2 * N)
                    || (r_pass != P_T && int'(r_k) == N - 1)) begin
                    n_i = '0;
                    n_j = '0;
                    n_carry = '0;
                    n_st = S_RD;
                end else begin
                    n_k = r_k + A2'(1);
                end
            end
            S_RD: n_st = S_MUL;
            S_MUL: n_st = S_ACC;
            S_ACC: begin
                n_carry = mac_hi;
                n_st = S_RD;
                if (r_j == top_j[A1-1:0]) begin
                    n_j = '0;
                    n_carry = '0;
                    if (r_pass == P_S) begin
                        // propagate the row carry upward through s
                        n_k = ij + A2'(1);
                        n_carry = mac_hi;
                        n_st = S_CARRY;
                    end else if (int'(r_i) == N - 1) begin
                        n_i = '0;
                        if (r_pass == P_T) begin
                            n_pass = P_Q;
                            n_k = '0;
                            n_st = S_CLR;
                        end else begin
                            n_pass = P_S;
                            n_st = S_RD;
                        end
                    end else begin
                        n_i = r_i + A1'(1);
                    end
                end else begin
                    n_j = r_j + A1'(1);
                end
            end
            S_CARRY: n_st = S_CARRYW;
            S_CARRYW: begin
                n_st = S_CARRY;
                n_carry = '0;
                if ((r_lo + r_carry) < r_carry) begin
                    n_carry = W'(1);
                end
                if (n_carry == '0 || int'(r_k) == 2 * N) begin
                    n_j = '0;
                    n_carry = '0;
                    if (int'(r_i) == N - 1) begin
                        n_k = A2'(mmul_pkg::WO);
                        n_i = '0;
                        n_st = S_OUT0;
                    end else begin
                        n_i = r_i + A1'(1);
                        n_st = S_RD;
                    end
                end else begin
                    n_k = r_k + A2'(1);
                end
            end
            S_OUT0: n_st = S_OUT1;
            S_OUT1: n_st = S_OUT2;
            S_OUT2: n_st = S_SEND;
            S_SEND: begin
                if (!r_ov) begin
                    if (int'(r_oidx) == N - 1) begin
                        n_st = S_IDLE;
                    end else begin
                        n_k = r_k + A2'(1);
                        n_st = S_OUT0;
                    end
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_pass <= P_T;
            r_sqr <= 1'b0;
            r_i <= '0;
            r_j <= '0;
            r_k <= '0;
            r_carry <= '0;
            r_ov <= 1'b0;
            r_oidx <= '0;
        end else begin
            r_st <= n_st;
            r_pass <= n_pass;
            r_sqr <= n_sqr;
            r_i <= n_i;
            r_j <= n_j;
            r_k <= n_k;
            r_carry <= n_carry;
            if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end else if (r_st == S_OUT2) begin
                r_ov <= 1'b1;
            end
            if (r_st == S_IDLE) begin
                r_oidx <= '0;
            end else if (r_st == S_SEND && !r_ov) begin
                r_oidx <= r_oidx + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_OUT2) begin
            r_out <= (mmul_pkg::BO == 0 ? r_lo
                      : ((r_lo >> mmul_pkg::BO) | (r_hi << (W - mmul_pkg::BO))))
                     & mmul_pkg::word_mask(r_oidx[A1-1:0]);
        end
    end

    assign o_valid = r_ov;
    assign o_result_word = r_out;
    assign o_result_index = r_oidx;
    assign o_last = (int'(r_oidx) == N - 1);
endmodule

[rtl/core/mmul_mac.sv]
// registered 64x64 multiply with accumulate of addend and carry word
module mmul_mac (
    input  logic                   i_clk,
    input  logic [mmul_pkg::W-1:0] i_x,
    input  logic [mmul_pkg::W-1:0] i_y,
    input  logic [mmul_pkg::W-1:0] i_add,
    input  logic [mmul_pkg::W-1:0] i_carry,
    output logic [mmul_pkg::W-1:0] o_lo,
    output logic [mmul_pkg::W-1:0] o_hi
);
    localparam int W = mmul_pkg::W;
    localparam int H = mmul_pkg::W / 2;

    logic [W-1:0]   r_p00;
    logic [W-1:0]   r_p01;
    logic [W-1:0]   r_p10;
    logic [W-1:0]   r_p11;
    logic [W:0]     r_ac;
    logic [2*W-1:0] sum;

    // four half-width partial products, combined in the next cycle
    always_ff @(posedge i_clk) begin
        r_p00 <= W'(i_x[H-1:0]) * W'(i_y[H-1:0]);
        r_p01 <= W'(i_x[H-1:0]) * W'(i_y[W-1:H]);
        r_p10 <= W'(i_x[W-1:H]) * W'(i_y[H-1:0]);
        r_p11 <= W'(i_x[W-1:H]) * W'(i_y[W-1:H]);
        r_ac <= {1'b0, i_add} + {1'b0, i_carry};
    end

    always_comb begin
        sum = {r_p11, r_p00}
              + {{H{1'b0}}, r_p01, {H{1'b0}}}
              + {{H{1'b0}}, r_p10, {H{1'b0}}}
              + {{(W-1){1'b0}}, r_ac};
    end

    assign o_lo = sum[W-1:0];
    assign o_hi = sum[2*W-1:W];
endmodule

[rtl/core/mmul_checker.sv]
// port-level checker for the montgomery multiplier
module mmul_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [63:0] o_result_word,
    input logic [4:0]  o_result_index,
    input logic        o_last
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_word) && $stable(o_result_index))
        else $error("stalled result changed");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == (o_result_index == 5'd16)))
        else $error("last flag mismatch");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken while result pending");
    a_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_result_index <= 5'd16)
        else $error("result index out of range");
endmodule

bind montgomery_mul_1038 mmul_checker u_mmul_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_result_word(o_result_word),
    .o_result_index(o_result_index), .o_last(o_last)
);
